@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("%m: invariant violated");
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/dtsf_pkg.sv @@
// ----------------------------------------------------------------------------
// dtsf_pkg
// Types and constants for the decimal text to scaled fixed-point parser.
// ----------------------------------------------------------------------------
package dtsf_pkg;

  localparam int MAX_DECIMALS = 18;
  localparam int WHOLE_W      = 64;
  localparam int FRAC_W       = 60;   // holds 10^18 - 1
  localparam int CNT_W        = 5;
  localparam int SCALE_W      = 32;
  localparam int DP_W         = 5;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CNT_W-1:0]   FRAC_CNT_SAT = 5'd31;
  localparam logic [SCALE_W-1:0] SCALE_RST    = 32'd10000;
  localparam logic [DP_W-1:0]    DP_RST       = 5'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_PLACES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_NEG = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRICE     = 2'd3;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_SIGN      = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_DECIMALS  = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_RANGE     = 3'd6
  } dtsf_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_ADD,
    S_FIN
  } dtsf_back_state_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [DP_W-1:0]    frac_places;
    logic               neg_enable;
    logic               price_mode;
  } dtsf_cfg_t;

  // Parse summary of one finished string
  typedef struct packed {
    logic [WHOLE_W-1:0] whole_acc;
    logic               whole_ovf;
    logic [FRAC_W-1:0]  frac_acc;
    logic [CNT_W-1:0]   frac_count;
    logic               seen_int_digit;
    logic               is_negative;
    logic               at_start;
    logic               bad_char;
    logic               complement;
  } dtsf_job_t;

endpackage

@@ rtl/dtsf_in_if.sv @@
// ----------------------------------------------------------------------------
// dtsf_in_if
// Character channel: one character beat per handshake.
// ----------------------------------------------------------------------------
interface dtsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_present;
  logic       last_char;
  logic       complement;

  modport source (output valid, char_code, char_present, last_char, complement,
                  input ready);
  modport sink   (input valid, char_code, char_present, last_char, complement,
                  output ready);
endinterface

@@ rtl/dtsf_out_if.sv @@
// ----------------------------------------------------------------------------
// dtsf_out_if
// Result channel: scaled value and status, one beat per string.
// ----------------------------------------------------------------------------
interface dtsf_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic [2:0]         status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

@@ rtl/dtsf_front.sv @@
// ----------------------------------------------------------------------------
// dtsf_front
// Character parser: accumulates whole and fraction digits, pushes a summary.
// ----------------------------------------------------------------------------
module dtsf_front
  import dtsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dtsf_in_if.sink   in_chan,
  input  logic      q_full,
  output logic      q_push,
  output dtsf_job_t q_job
);

  logic [WHOLE_W-1:0] whole_r, whole_nxt;
  logic               wovf_r, wovf_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [CNT_W-1:0]   fcnt_r, fcnt_nxt;
  logic               seen_pt_r, seen_pt_nxt;
  logic               seen_int_r, seen_int_nxt;
  logic               neg_r, neg_nxt;
  logic               start_r, start_nxt;
  logic               bad_r, bad_nxt;

  logic               accept;
  logic               digit;
  logic [3:0]         dval;
  logic               cont;
  logic [WHOLE_W+3:0] whole_x10;
  logic [7:0]         c;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign c             = in_chan.char_code;
  assign digit         = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dval          = digit ? c[3:0] : 4'd0;
  assign whole_x10     = ({4'd0, whole_r} << 3) + ({4'd0, whole_r} << 1)
                         + {{WHOLE_W{1'b0}}, dval};

  always_comb begin
    whole_nxt    = whole_r;
    wovf_nxt     = wovf_r;
    frac_nxt     = frac_r;
    fcnt_nxt     = fcnt_r;
    seen_pt_nxt  = seen_pt_r;
    seen_int_nxt = seen_int_r;
    neg_nxt      = neg_r;
    start_nxt    = start_r;
    bad_nxt      = bad_r;
    cont         = 1'b1;

    if (accept && in_chan.char_present) begin
      // A sign counts only as the first character
      if (start_r) begin
        start_nxt = 1'b0;
        if (c == CH_MINUS || c == CH_PLUS) begin
          neg_nxt = (c == CH_MINUS);
          cont    = 1'b0;
        end
      end
      if (cont) begin
        if (!seen_pt_r) begin
          if (c == CH_POINT) begin
            seen_pt_nxt = 1'b1;
          end else begin
            seen_int_nxt = 1'b1;
            if (!digit) begin
              bad_nxt = 1'b1;
            end else if (!wovf_r) begin
              if (|whole_x10[WHOLE_W+3:WHOLE_W]) begin
                wovf_nxt = 1'b1;
              end else begin
                whole_nxt = whole_x10[WHOLE_W-1:0];
              end
            end
          end
        end else begin
          // Drop digits past the accumulator limit; the count still reports them
          if (digit && (fcnt_r < CNT_W'(MAX_DECIMALS))) begin
            frac_nxt = (frac_r << 3) + (frac_r << 1) + {{(FRAC_W-4){1'b0}}, dval};
          end
          if (!digit) begin
            bad_nxt = 1'b1;
          end
          if (fcnt_r < FRAC_CNT_SAT) begin
            fcnt_nxt = fcnt_r + 1'b1;
          end
        end
      end
    end
  end

  assign q_push               = accept && in_chan.last_char;
  assign q_job.whole_acc      = whole_nxt;
  assign q_job.whole_ovf      = wovf_nxt;
  assign q_job.frac_acc       = frac_nxt;
  assign q_job.frac_count     = fcnt_nxt;
  assign q_job.seen_int_digit = seen_int_nxt;
  assign q_job.is_negative    = neg_nxt;
  assign q_job.at_start       = start_nxt;
  assign q_job.bad_char       = bad_nxt;
  assign q_job.complement     = in_chan.complement;

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      whole_r    <= '0;
      wovf_r     <= 1'b0;
      frac_r     <= '0;
      fcnt_r     <= '0;
      seen_pt_r  <= 1'b0;
      seen_int_r <= 1'b0;
      neg_r      <= 1'b0;
      start_r    <= 1'b1;
      bad_r      <= 1'b0;
    end else begin
      whole_r    <= whole_nxt;
      wovf_r     <= wovf_nxt;
      frac_r     <= frac_nxt;
      fcnt_r     <= fcnt_nxt;
      seen_pt_r  <= seen_pt_nxt;
      seen_int_r <= seen_int_nxt;
      neg_r      <= neg_nxt;
      start_r    <= start_nxt;
      bad_r      <= bad_nxt;
    end
  end

endmodule

@@ rtl/dtsf_queue.sv @@
// ----------------------------------------------------------------------------
// dtsf_queue
// Small FIFO of parse summaries between the parser and the finisher.
// ----------------------------------------------------------------------------
module dtsf_queue
  import dtsf_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dtsf_job_t push_job,
  input  logic      pop,
  output dtsf_job_t pop_job,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  dtsf_job_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W_Q'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/dtsf_back.sv @@
// ----------------------------------------------------------------------------
// dtsf_back
// Finisher: status checks, fraction padding, whole*scale and result register.
// ----------------------------------------------------------------------------
module dtsf_back
  import dtsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dtsf_cfg_t  cfg,
  input  dtsf_job_t  job,
  input  logic       q_empty,
  output logic       q_pop,
  dtsf_out_if.source out_chan
);

  dtsf_back_state_t   state_r, state_nxt;
  logic [WHOLE_W-1:0] whole_r, whole_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [CNT_W-1:0]   pad_r, pad_nxt;
  logic               neg_r, neg_nxt;
  logic               comp_r, comp_nxt;
  dtsf_status_t       stat_r, stat_nxt;
  logic [63:0]        prod_lo_r, prod_lo_nxt;
  logic [63:0]        prod_hi_r, prod_hi_nxt;
  logic [95:0]        sum_r, sum_nxt;
  logic [96:0]        total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [63:0] out_value_r;
  dtsf_status_t       out_status_r;

  logic [DP_W-1:0]    dp;
  dtsf_status_t       early;
  logic [CNT_W-1:0]   pad_new;
  logic [31:0]        mul_a;
  logic [63:0]        mul_p;
  logic [63:0]        mag;
  logic [63:0]        scale_x;
  dtsf_status_t       fin_stat;
  logic [63:0]        fin_value;
  logic               out_load;

  assign dp      = (cfg.frac_places > DP_W'(MAX_DECIMALS)) ? DP_W'(MAX_DECIMALS)
                                                           : cfg.frac_places;
  assign pad_new = dp - job.frac_count;

  // Checks in priority order
  always_comb begin
    if (job.at_start || cfg.scale == '0) begin
      early = ST_EMPTY;
    end else if (job.is_negative && !cfg.neg_enable) begin
      early = ST_SIGN;
    end else if (!job.seen_int_digit) begin
      early = ST_MALFORMED;
    end else if (job.frac_count > dp) begin
      early = ST_DECIMALS;
    end else if (job.bad_char) begin
      early = ST_MALFORMED;
    end else if (job.whole_ovf) begin
      early = ST_OVERFLOW;
    end else begin
      early = ST_OK;
    end
  end

  // One 32x32 multiplier, used for both halves of the whole part
  assign mul_a   = (state_r == S_MUL_HI) ? whole_r[63:32] : whole_r[31:0];
  assign mul_p   = mul_a * cfg.scale;
  assign mag     = total_r[63:0];
  assign scale_x = {32'd0, cfg.scale};

  always_comb begin
    if (stat_r != ST_OK) begin
      fin_stat = stat_r;
    end else if (|total_r[96:63]) begin
      fin_stat = ST_OVERFLOW;
    end else if (cfg.price_mode && ((neg_r && mag != '0) || mag > scale_x)) begin
      fin_stat = ST_RANGE;
    end else begin
      fin_stat = ST_OK;
    end
    if (fin_stat != ST_OK) begin
      fin_value = '0;
    end else if (cfg.price_mode && comp_r) begin
      fin_value = scale_x - mag;
    end else if (neg_r) begin
      fin_value = '0 - mag;
    end else begin
      fin_value = mag;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    whole_nxt   = whole_r;
    frac_nxt    = frac_r;
    pad_nxt     = pad_r;
    neg_nxt     = neg_r;
    comp_nxt    = comp_r;
    stat_nxt    = stat_r;
    prod_lo_nxt = prod_lo_r;
    prod_hi_nxt = prod_hi_r;
    sum_nxt     = sum_r;
    total_nxt   = total_r;
    q_pop       = 1'b0;
    out_load    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          whole_nxt = job.whole_acc;
          frac_nxt  = job.frac_acc;
          pad_nxt   = pad_new;
          neg_nxt   = job.is_negative;
          comp_nxt  = job.complement;
          stat_nxt  = early;
          if (early != ST_OK) begin
            state_nxt = S_FIN;
          end else if (pad_new == '0) begin
            state_nxt = S_MUL_LO;
          end else begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        // Pad the fraction one decimal place per cycle
        frac_nxt = (frac_r << 3) + (frac_r << 1);
        pad_nxt  = pad_r - 1'b1;
        if (pad_r == CNT_W'(1)) begin
          state_nxt = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        prod_lo_nxt = mul_p;
        state_nxt   = S_MUL_HI;
      end
      S_MUL_HI: begin
        prod_hi_nxt = mul_p;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        sum_nxt   = {prod_hi_r, 32'd0} + {32'd0, prod_lo_r};
        state_nxt = S_ADD;
      end
      S_ADD: begin
        total_nxt = {1'b0, sum_r} + {37'd0, frac_r};
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Hold until the result register frees up
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    whole_r   <= whole_nxt;
    frac_r    <= frac_nxt;
    pad_r     <= pad_nxt;
    neg_r     <= neg_nxt;
    comp_r    <= comp_nxt;
    stat_r    <= stat_nxt;
    prod_lo_r <= prod_lo_nxt;
    prod_hi_r <= prod_hi_nxt;
    sum_r     <= sum_nxt;
    total_r   <= total_nxt;
    if (out_load) begin
      out_value_r  <= fin_value;
      out_status_r <= fin_stat;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = out_value_r;
  assign out_chan.status       = out_status_r;

endmodule

@@ rtl/decimal_text_to_scaled_fixed.sv @@
// ----------------------------------------------------------------------------
// decimal_text_to_scaled_fixed
// Streaming ASCII decimal parser with scaled fixed-point result and status.
// ----------------------------------------------------------------------------
// Throughput: one character beat per cycle while the summary queue has room.
// Finisher: pads the fraction (0..18 places), then runs both multiply halves,
//   the sum, the add and the result load; a failed status check goes straight
//   to the result load, and the next summary is popped only after that load.
// Reset: synchronous, active low; registers return to scale 10000, 4 places.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_text_to_scaled_fixed
  import dtsf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_wdata,
  dtsf_in_if.sink              in_chan,
  dtsf_out_if.source           out_chan
);

  dtsf_cfg_t cfg_r;
  dtsf_job_t push_job, pop_job;
  logic      q_push, q_pop, q_full, q_empty;
  logic      res_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale       <= SCALE_RST;
      cfg_r.frac_places <= DP_RST;
      cfg_r.neg_enable  <= 1'b0;
      cfg_r.price_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE:      cfg_r.scale       <= cfg_wdata;
        CFG_DEC_PLACES: cfg_r.frac_places <= cfg_wdata[DP_W-1:0];
        CFG_ALLOW_NEG:  cfg_r.neg_enable  <= cfg_wdata[0];
        CFG_PRICE:      cfg_r.price_mode  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  dtsf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  dtsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  dtsf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .job      (pop_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  assign res_err = out_chan.valid && (out_chan.status != ST_OK);

  `ASSERT_ALWAYS(a_queue_flags, clk, rst_n, !(q_full && q_empty))
  `ASSERT_IMPL(a_no_push_when_full, clk, rst_n, q_push, !q_full)
  `ASSERT_IMPL(a_err_value_zero, clk, rst_n, res_err, out_chan.result_value == '0)

endmodule

@@ tb/sv/decimal_text_to_scaled_fixed_test.sv @@
// ----------------------------------------------------------------------------
// decimal_text_to_scaled_fixed_test
// Self-checking bench for the streaming decimal text parser. Number strings
// are fed one character beat at a time. A built-in parser model predicts value
// and status for each string (typed table rows give their own), and each result
// beat is compared against the oldest prediction. A short table of hand-picked
// strings comes first, then random strings (mostly well-formed, some noise)
// under several register settings, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module decimal_text_to_scaled_fixed_test
  import dtsf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int        HOLD_CYCLES   = 400;
  localparam int        SETTLE_CYCLES = 32;
  localparam int        CYCLE_LIMIT   = 600000;
  localparam int        RANDOM_ITEMS  = 860;
  localparam int        PHASES        = 7;
  localparam bit [63:0] MAX_POS       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] MAX_U64       = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    bit [7:0] code;
    bit       present;
    bit       last;
    bit       comp;
  } char_beat_t;

  typedef struct {
    bit [63:0]    value;
    dtsf_status_t status;
  } number_result_t;

  typedef struct {
    bit [31:0]    scale;
    bit [4:0]     places;
    bit           neg_ok;
    bit           price;
    string        text;
    bit           end_gap;   // close with an empty beat instead of on the last character
    bit           comp;
    bit           typed;
    longint       value;
    dtsf_status_t status;
  } directed_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SCALE_W-1:0]   cfg_wdata;

  dtsf_in_if  in_bus ();
  dtsf_out_if out_bus ();

  decimal_text_to_scaled_fixed u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // Parser model state and register copy
  dtsf_cfg_t   regs_now;
  bit [63:0]   whole_acc;
  bit          whole_ovf;
  bit [63:0]   frac_acc;
  bit [4:0]    frac_cnt;
  bit          in_fraction;
  bit          int_seen;
  bit          minus;
  bit          fresh;
  bit          bad_char;

  number_result_t awaited_results[$];
  char_beat_t     line_beats[$];

  bit quiet;
  bit hold_req;
  int mismatches;
  int beats_sent;
  int strings_sent;
  int settings_used;
  int cycles;
  int status_seen[8];

  directed_row_t directed_rows[19] = '{
    '{32'd10000, 5'd4, 1'b0, 1'b0, "",      1'b1, 1'b0, 1'b1, 0,      ST_EMPTY},
    '{32'd10000, 5'd4, 1'b0, 1'b0, "0",     1'b0, 1'b1, 1'b1, 0,      ST_OK},
    '{32'd10000, 5'd4, 1'b0, 1'b0, "+1.5",  1'b0, 1'b0, 1'b1, 15000,  ST_OK},
    '{32'd10000, 5'd4, 1'b0, 1'b0, "12",    1'b1, 1'b0, 1'b1, 120000, ST_OK},
    '{32'd10000, 5'd4, 1'b0, 1'b0, "-0",    1'b0, 1'b0, 1'b1, 0,      ST_SIGN},
    '{32'd10000, 5'd4, 1'b0, 1'b0, ".5",    1'b0, 1'b0, 1'b1, 0,      ST_MALFORMED},
    '{32'd10000, 5'd4, 1'b0, 1'b0, "1.23456", 1'b0, 1'b0, 1'b1, 0,    ST_DECIMALS},
    '{32'd10000, 5'd4, 1'b0, 1'b0, "1-",    1'b0, 1'b0, 1'b1, 0,      ST_MALFORMED},
    '{32'd10000, 5'd4, 1'b0, 1'b0, "1.2.3", 1'b0, 1'b0, 1'b1, 0,      ST_MALFORMED},
    '{32'd10000, 5'd4, 1'b0, 1'b0, "9a",    1'b0, 1'b0, 1'b1, 0,      ST_MALFORMED},
    '{32'd0,     5'd4, 1'b0, 1'b0, "5",     1'b0, 1'b0, 1'b1, 0,      ST_EMPTY},
    '{32'hFFFF_FFFF, 5'd31, 1'b1, 1'b0, "-1.5", 1'b0, 1'b0, 1'b0, 0, ST_OK},
    '{32'hFFFF_FFFF, 5'd31, 1'b1, 1'b0, "3000000000", 1'b0, 1'b0, 1'b1, 0, ST_OVERFLOW},
    '{32'd100,   5'd2, 1'b1, 1'b1, "0.5",   1'b0, 1'b0, 1'b1, 50,     ST_OK},
    '{32'd100,   5'd2, 1'b1, 1'b1, "0.25",  1'b0, 1'b1, 1'b1, 75,     ST_OK},
    '{32'd100,   5'd2, 1'b1, 1'b1, "1.01",  1'b0, 1'b0, 1'b1, 0,      ST_RANGE},
    '{32'd100,   5'd2, 1'b1, 1'b1, "-0",    1'b0, 1'b1, 1'b1, 100,    ST_OK},
    '{32'd100,   5'd2, 1'b1, 1'b1, "-0.01", 1'b0, 1'b0, 1'b1, 0,      ST_RANGE},
    '{32'd7,     5'd0, 1'b0, 1'b0, "7.",    1'b0, 1'b0, 1'b1, 49,     ST_OK}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic void fresh_number();
    whole_acc   = '0;
    whole_ovf   = 1'b0;
    frac_acc    = '0;
    frac_cnt    = '0;
    in_fraction = 1'b0;
    int_seen    = 1'b0;
    minus       = 1'b0;
    fresh       = 1'b1;
    bad_char    = 1'b0;
  endfunction

  function automatic bit [63:0] ten_to(int n);
    bit [63:0] p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  function automatic int clamped_places();
    return (regs_now.frac_places > MAX_DECIMALS) ? MAX_DECIMALS
                                                  : int'(regs_now.frac_places);
  endfunction

  function automatic void absorb_char(bit [7:0] c);
    bit        is_digit;
    bit [63:0] d;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = is_digit ? 64'(c - CH_ZERO) : 64'd0;
    if (fresh) begin
      fresh = 1'b0;
      if (c == CH_MINUS || c == CH_PLUS) begin
        minus = (c == CH_MINUS);
        return;
      end
    end
    if (!in_fraction) begin
      if (c == CH_POINT) begin
        in_fraction = 1'b1;
        return;
      end
      int_seen = 1'b1;
      if (!is_digit) begin
        bad_char = 1'b1;
        return;
      end
      if (!whole_ovf) begin
        if (whole_acc > (MAX_U64 - d) / 10) whole_ovf = 1'b1;
        else whole_acc = whole_acc * 10 + d;
      end
      return;
    end
    // fraction: stop accumulating past the widest padding, keep counting
    if (is_digit && frac_cnt < MAX_DECIMALS) frac_acc = frac_acc * 10 + d;
    if (!is_digit) bad_char = 1'b1;
    if (frac_cnt < FRAC_CNT_SAT) frac_cnt = frac_cnt + 1'b1;
  endfunction

  function automatic void close_number(input bit comp, output bit [63:0] value,
                                       output dtsf_status_t st);
    int        places;
    bit [63:0] frac;
    bit [63:0] mag;
    value  = '0;
    st     = ST_OK;
    places = clamped_places();
    if (fresh || regs_now.scale == 0) st = ST_EMPTY;
    else if (minus && !regs_now.neg_enable) st = ST_SIGN;
    else if (!int_seen) st = ST_MALFORMED;
    else if (frac_cnt > places) st = ST_DECIMALS;
    else if (bad_char) st = ST_MALFORMED;
    else if (whole_ovf) st = ST_OVERFLOW;
    else begin
      frac = frac_acc * ten_to(places - int'(frac_cnt));
      if (frac > MAX_POS || whole_acc > (MAX_POS - frac) / 64'(regs_now.scale)) begin
        st = ST_OVERFLOW;
      end else begin
        mag   = whole_acc * 64'(regs_now.scale) + frac;
        value = minus ? (64'd0 - mag) : mag;
        if (regs_now.price_mode) begin
          if ((minus && mag != 0) || mag > 64'(regs_now.scale)) st = ST_RANGE;
          else if (comp) value = 64'(regs_now.scale) - mag;
        end
      end
    end
    if (st != ST_OK) value = '0;
  endfunction

  function automatic bit predict_beat(input char_beat_t b, output number_result_t r);
    if (b.present) absorb_char(b.code);
    if (!b.last) return 1'b0;
    close_number(b.comp, r.value, r.status);
    fresh_number();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [7:0] noise_char();
    string syms;
    syms = "+-.0123456789";
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return syms[$urandom_range(0, 12)];
  endfunction

  function automatic bit [7:0] digit_char();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic void compose_number();
    bit [7:0]   txt[$];
    int         r;
    int         n_int;
    int         n_frac;
    int         places;
    bit         comp;
    bit         tiny;
    char_beat_t b;
    line_beats.delete();
    places = clamped_places();
    comp   = 1'($urandom_range(0, 1));
    tiny   = 1'b0;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(0, 6)) txt.push_back(noise_char());
    end else begin
      r = $urandom_range(0, 99);
      if (r < 20) txt.push_back(CH_MINUS);
      else if (r < 30) txt.push_back(CH_PLUS);
      r = $urandom_range(0, 99);
      if (r < 5) n_int = 0;
      else if (regs_now.price_mode && r < 60) begin
        n_int = 1;
        tiny  = 1'b1;
      end
      else if (r < 80) n_int = $urandom_range(1, 4);
      else if (r < 95) n_int = $urandom_range(5, 12);
      else n_int = $urandom_range(13, 22);
      for (int i = 0; i < n_int; i++) begin
        txt.push_back(tiny ? CH_ZERO + 8'($urandom_range(0, 1)) : digit_char());
      end
      if ($urandom_range(0, 99) < 70) begin
        txt.push_back(CH_POINT);
        r = $urandom_range(0, 99);
        if (r < 85) n_frac = $urandom_range(0, places);
        else if (r < 97) n_frac = places + $urandom_range(1, 3);
        else n_frac = $urandom_range(19, 40);
        repeat (n_frac) txt.push_back(digit_char());
      end
      // break a few otherwise clean strings
      if ($urandom_range(0, 99) < 8) txt.insert($urandom_range(0, txt.size()), noise_char());
    end
    foreach (txt[i]) begin
      if ($urandom_range(0, 99) < 4) begin
        b = '{code: 8'($urandom_range(0, 255)), present: 1'b0, last: 1'b0,
              comp: 1'($urandom_range(0, 1))};
        line_beats.push_back(b);
      end
      b = '{code: txt[i], present: 1'b1, last: 1'b0, comp: 1'($urandom_range(0, 1))};
      line_beats.push_back(b);
    end
    if (line_beats.size() == 0 || $urandom_range(0, 9) == 0) begin
      b = '{code: 8'($urandom_range(0, 255)), present: 1'b0, last: 1'b1, comp: comp};
      line_beats.push_back(b);
    end else begin
      b = line_beats.pop_back();
      b.last = 1'b1;
      b.comp = comp;
      line_beats.push_back(b);
    end
  endfunction

  function automatic dtsf_cfg_t phase_settings(int p);
    dtsf_cfg_t c;
    int        r;
    case (p)
      0: c = '{scale: 32'd1, frac_places: 5'd0, neg_enable: 1'b1, price_mode: 1'b0};
      1: c = '{scale: 32'hFFFF_FFFF, frac_places: 5'd18, neg_enable: 1'b0,
               price_mode: 1'b0};
      2: c = '{scale: 32'd100, frac_places: 5'd2, neg_enable: 1'b1, price_mode: 1'b1};
      3: c = '{scale: 32'd0, frac_places: 5'd31, neg_enable: 1'b1, price_mode: 1'b1};
      default: begin
        r = $urandom_range(0, 99);
        if (r < 30) c.scale = $urandom();
        else if (r < 60) c.scale = $urandom_range(1, 1000);
        else c.scale = 32'(ten_to($urandom_range(0, 9)));
        c.frac_places = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(0, 8))
                                                     : 5'($urandom_range(0, 31));
        c.neg_enable  = 1'($urandom_range(0, 1));
        c.price_mode  = 1'($urandom_range(0, 1));
      end
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers (all entered and left at a falling edge)
  // --------------------------------------------------------------------------
  task automatic send_beat(char_beat_t b, bit typed, number_result_t typed_res);
    int             gap;
    number_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.char_code    <= b.code;
    in_bus.char_present <= b.present;
    in_bus.last_char    <= b.last;
    in_bus.complement   <= b.comp;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    beats_sent++;
    if (predict_beat(b, r)) begin
      if (typed) r = typed_res;
      awaited_results.push_back(r);
      strings_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_number(bit typed, number_result_t typed_res);
    foreach (line_beats[i]) send_beat(line_beats[i], typed, typed_res);
  endtask

  // Drop valid, drain every pending result, then let the finisher go quiet.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_settings(dtsf_cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCALE;
    cfg_wdata <= c.scale;
    @(negedge clk);
    cfg_index <= CFG_DEC_PLACES;
    cfg_wdata <= ($urandom() << DP_W) | 32'(c.frac_places);
    @(negedge clk);
    cfg_index <= CFG_ALLOW_NEG;
    cfg_wdata <= ($urandom() << 1) | 32'(c.neg_enable);
    @(negedge clk);
    cfg_index <= CFG_PRICE;
    cfg_wdata <= ($urandom() << 1) | 32'(c.price_mode);
    @(negedge clk);
    cfg_we   <= 1'b0;
    regs_now  = c;
    settings_used++;
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dtsf_cfg_t      row_cfg;
    char_beat_t     b;
    number_result_t typed_res;
    int             target;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_SCALE;
    cfg_wdata           = '0;
    in_bus.valid        = 1'b0;
    in_bus.char_code    = '0;
    in_bus.char_present = 1'b0;
    in_bus.last_char    = 1'b0;
    in_bus.complement   = 1'b0;
    quiet               = 1'b0;
    hold_req            = 1'b0;
    regs_now = '{scale: SCALE_RST, frac_places: DP_RST, neg_enable: 1'b0,
                 price_mode: 1'b0};
    fresh_number();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      row_cfg = '{scale: directed_rows[k].scale, frac_places: directed_rows[k].places,
                  neg_enable: directed_rows[k].neg_ok, price_mode: directed_rows[k].price};
      if (row_cfg != regs_now) begin
        settle();
        load_settings(row_cfg);
      end
      line_beats.delete();
      for (int i = 0; i < directed_rows[k].text.len(); i++) begin
        b = '{code: directed_rows[k].text[i], present: 1'b1, last: 1'b0,
              comp: directed_rows[k].comp};
        line_beats.push_back(b);
      end
      if (directed_rows[k].end_gap || line_beats.size() == 0) begin
        b = '{code: 8'h00, present: 1'b0, last: 1'b1, comp: directed_rows[k].comp};
      end else begin
        b = line_beats.pop_back();
        b.last = 1'b1;
      end
      line_beats.push_back(b);
      typed_res = '{value: 64'(directed_rows[k].value), status: directed_rows[k].status};
      send_number(directed_rows[k].typed, typed_res);
    end

    typed_res = '{value: '0, status: ST_OK};
    for (int p = 0; p < PHASES; p++) begin
      settle();
      load_settings(phase_settings(p));
      quiet = ($urandom_range(0, 3) == 0);
      // stall the result side for a long stretch while strings keep coming
      if (p == 1) hold_req = 1'b1;
      target = beats_sent + RANDOM_ITEMS / PHASES;
      while (beats_sent < target) begin
        compose_number();
        send_number(1'b0, typed_res);
      end
    end
    settle();

    $display("Sent %0d input beats in %0d strings over %0d register settings,",
             beats_sent, strings_sent, settings_used);
    $display("statuses seen: ok %0d empty %0d sign %0d malformed %0d decimals %0d ovf %0d range %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_SIGN],
             status_seen[ST_MALFORMED], status_seen[ST_DECIMALS], status_seen[ST_OVERFLOW],
             status_seen[ST_RANGE]);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side ready with random stalls and one long hold-off
  initial begin : result_sink
    int stall;
    out_bus.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    number_result_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("result %0d status %0d with no string pending",
                                out_bus.result_value, out_bus.status));
      end else begin
        want = awaited_results.pop_front();
        if (out_bus.result_value !== want.value) begin
          note_mismatch($sformatf("value %0d, predicted %0d", out_bus.result_value,
                                  $signed(want.value)));
        end
        if (out_bus.status !== want.status) begin
          note_mismatch($sformatf("status %0d, predicted %0d (%s)", out_bus.status,
                                  want.status, want.status.name()));
        end
        status_seen[want.status]++;
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still pending", cycles,
             awaited_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ decimal_text_to_scaled_fixed.f @@
+incdir+rtl
rtl/dtsf_pkg.sv
rtl/dtsf_in_if.sv
rtl/dtsf_out_if.sv
rtl/dtsf_front.sv
rtl/dtsf_queue.sv
rtl/dtsf_back.sv
rtl/decimal_text_to_scaled_fixed.sv
tb/sv/decimal_text_to_scaled_fixed_test.sv
